// ----- rtl/core/tach_pkg.sv -----
package tach_pkg;

  localparam int unsigned TIME_WIDTH        = 32;
  localparam int unsigned MICROSECS_PER_SEC = 1000000;
  localparam int unsigned SECS_PER_MINUTE   = 60;
  localparam int unsigned RATE_W            = 15;
  localparam int unsigned RATE_MAX          = (1 << RATE_W) - 1;

  // 60e6 fits in 26 bits
  localparam int unsigned DIVIDEND   = SECS_PER_MINUTE * MICROSECS_PER_SEC;
  localparam int unsigned DVD_W      = $clog2(DIVIDEND + 1);
  localparam int unsigned CNT_W      = $clog2(DVD_W + 1);
  localparam int unsigned MIN_PERIOD = DIVIDEND / RATE_MAX;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_TICK = 1'b1;

endpackage

// ----- rtl/core/tach_div.sv -----
module tach_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start_i,
  input  logic [tach_pkg::TIME_WIDTH-1:0]      divisor_i,
  output logic                                 done_o,
  output logic [tach_pkg::DVD_W-1:0]           quotient_o
);
  import tach_pkg::*;

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIME_WIDTH-1:0] rem_q, rem_d;
  logic [TIME_WIDTH-1:0] dsr_q, dsr_d;
  logic [DVD_W-1:0]      dvd_q, dvd_d;
  logic [DVD_W-1:0]      quo_q, quo_d;

  logic [TIME_WIDTH:0]   shifted;
  logic [TIME_WIDTH+1:0] diff;
  logic                  fits;

  // one restoring step per cycle through the shared subtractor
  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign fits    = ~diff[TIME_WIDTH+1];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DVD_W);
      rem_d  = '0;
      dsr_d  = divisor_i;
      dvd_d  = DVD_W'(DIVIDEND);
      quo_d  = '0;
    end else if (busy_q) begin
      rem_d = fits ? diff[TIME_WIDTH-1:0] : shifted[TIME_WIDTH-1:0];
      quo_d = {quo_q[DVD_W-2:0], fits};
      dvd_d = {dvd_q[DVD_W-2:0], 1'b0};
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/core/pulse_period_tachometer.sv -----
// pulse period tachometer: turns edge timestamps (microseconds) into pulses per minute
// input channel s_axis: tuser carries the kind (edge capture or period tick), tdata the
// 32-bit timestamp of an edge. output channel m_axis: tdata the 15-bit rate, tuser the
// timeout flag.
// a tick arms an idle block; the opening edge capture then stores its timestamp, the closing one
// measures the period and yields 60000000 / max(period, 1831), saturated at 32767, or 0
// for a zero period, and disarms. a tick while still armed restarts and sends a timeout 0.
// items without a result are taken at one per cycle. a measuring edge runs a restoring
// divider, one quotient bit per cycle; the saturated quotient goes to the result register
// and then to the output register, as a timeout result does without the divider.
// the input side is ready whenever no item is at work, also while a result waits in the
// output register; a result that finds the output register still full holds the block
// (not ready) until the receiver takes the waiting one.
// reset leaves the block disarmed, waiting for a tick to arm it, with nothing to send.
module pulse_period_tachometer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] capture_time
  input  logic [0:0]  s_axis_tuser_i,   // [0] opcode
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [14:0] pulses_per_minute, [15] zero
  output logic [0:0]  m_axis_tuser_o    // [0] timed_out
);
  import tach_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic                  armed_q, armed_d;
  logic                  first_q, first_d;
  logic [TIME_WIDTH-1:0] prev_q, prev_d;
  logic [RATE_W-1:0]     res_rate_q, res_rate_d;
  logic                  res_to_q, res_to_d;
  logic                  out_valid_q, out_valid_d;
  logic [RATE_W-1:0]     out_rate_q, out_rate_d;
  logic                  out_to_q, out_to_d;

  logic                  in_acc;
  logic                  out_load;
  logic [TIME_WIDTH-1:0] cap_time;
  logic [TIME_WIDTH-1:0] period;
  logic [TIME_WIDTH-1:0] divisor;
  logic                  div_start;
  logic                  div_done;
  logic [DVD_W-1:0]      quotient;
  logic [RATE_W-1:0]     sat_rate;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign cap_time        = s_axis_tdata_i[TIME_WIDTH-1:0];
  assign period          = cap_time - prev_q;
  assign divisor         = (period < TIME_WIDTH'(MIN_PERIOD)) ? TIME_WIDTH'(MIN_PERIOD) : period;
  assign div_start       = in_acc && (s_axis_tuser_i[0] == OP_EDGE) && armed_q && !first_q
                           && (period != '0);
  assign sat_rate        = (|quotient[DVD_W-1:RATE_W]) ? RATE_W'(RATE_MAX)
                                                       : quotient[RATE_W-1:0];
  assign out_load        = (state_q == ST_EMIT) && (!out_valid_q || m_axis_tready_i);

  tach_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quotient_o(quotient)
  );

  always_comb begin
    state_d     = state_q;
    armed_d     = armed_q;
    first_d     = first_q;
    prev_d      = prev_q;
    res_rate_d  = res_rate_q;
    res_to_d    = res_to_q;
    out_valid_d = out_valid_q;
    out_rate_d  = out_rate_q;
    out_to_d    = out_to_q;

    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser_i[0] == OP_TICK) begin
            first_d = 1'b1;
            armed_d = 1'b1;
            if (armed_q) begin
              res_rate_d = '0;
              res_to_d   = 1'b1;
              state_d    = ST_EMIT;
            end
          end else if (armed_q) begin
            prev_d = cap_time;
            if (first_q) begin
              first_d = 1'b0;
            end else begin
              armed_d  = 1'b0;
              first_d  = 1'b1;
              res_to_d = 1'b0;
              if (period == '0) begin
                res_rate_d = '0;
                state_d    = ST_EMIT;
              end else begin
                state_d = ST_DIV;
              end
            end
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_rate_d = sat_rate;
          res_to_d   = 1'b0;
          state_d    = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          out_rate_d  = res_rate_q;
          out_to_d    = res_to_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      armed_q     <= 1'b0;
      first_q     <= 1'b1;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      armed_q     <= armed_d;
      first_q     <= first_d;
      prev_q      <= prev_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_rate_q <= res_rate_d;
    res_to_q   <= res_to_d;
    out_rate_q <= out_rate_d;
    out_to_q   <= out_to_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {1'b0, out_rate_q};
  assign m_axis_tuser_o  = out_to_q;

  // the divider only finishes while a measurement is pending
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider done outside of a measurement");

  // a timeout result always carries a zero rate
  a_timeout_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o[0]) |-> m_axis_tdata_o == 16'h0000)
    else $error("timeout result with nonzero rate");

  // a tick that finds the block armed keeps it armed and queues a timeout
  a_tick_armed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s_axis_tuser_i[0] == OP_TICK && armed_q) |=>
      (armed_q && first_q && res_to_q && state_q == ST_EMIT))
    else $error("tick while armed mishandled");

  // a measuring edge with a nonzero period disarms and starts the divider
  a_edge_measure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |=> (!armed_q && state_q == ST_DIV))
    else $error("measuring edge did not start a division");

endmodule
